/* rtl/m7fs_pkg.sv */
// shared types, codes and helper functions for the modem7 filename sender
package m7fs_pkg;

    localparam int NAME_LENGTH = 11;

    localparam logic [7:0] CH_ACK = 8'h06;
    localparam logic [7:0] CH_NAK = 8'h15;
    localparam logic [7:0] CH_SUB = 8'h1A;
    localparam logic [7:0] CH_U   = 8'h75;

    localparam logic [3:0] LAST_INDEX = 4'(NAME_LENGTH);
    localparam logic [3:0] RETRY_MAX  = 4'hF;

    // configuration register indexes
    localparam logic [1:0] CFG_NAME_FIRST = 2'd0;
    localparam logic [1:0] CFG_NAME_EXT   = 2'd1;
    localparam logic [1:0] CFG_RETRY_LIM  = 2'd2;

    localparam logic [63:0] NAME_FIRST_RST = 64'h2020202020202020;
    localparam logic [23:0] NAME_EXT_RST   = 24'h202020;
    localparam logic [3:0]  RETRY_LIM_RST  = 4'd10;

    typedef enum logic [1:0] {
        MODE_START   = 2'd0,
        MODE_RX      = 2'd1,
        MODE_TIMEOUT = 2'd2,
        MODE_NONE    = 2'd3
    } t_mode;

    typedef enum logic [2:0] {
        ST_BUSY    = 3'd0,
        ST_OK      = 3'd1,
        ST_RETRY   = 3'd2,
        ST_CARRIER = 3'd3,
        ST_IDLE    = 3'd4
    } t_status;

    typedef enum logic [2:0] {
        PH_IDLE = 3'd0,
        PH_NAK  = 3'd1,
        PH_ACK  = 3'd2,
        PH_CKSM = 3'd3,
        PH_DONE = 3'd4
    } t_phase;

    typedef struct packed {
        logic       has_byte;
        logic [7:0] tx_byte;
        t_status    status;
        logic       last;
    } t_result;

    // one or two results handed from the core to the output buffer
    typedef struct packed {
        logic    load;
        logic    two;
        t_result r0;
        t_result r1;
    } t_push;

    function automatic logic [7:0] name_char(input logic [63:0] first,
                                             input logic [23:0] ext,
                                             input logic [3:0]  idx);
        logic [7:0] c;
        c = 8'h00;
        case (idx)
            4'd0:    c = first[7:0];
            4'd1:    c = first[15:8];
            4'd2:    c = first[23:16];
            4'd3:    c = first[31:24];
            4'd4:    c = first[39:32];
            4'd5:    c = first[47:40];
            4'd6:    c = first[55:48];
            4'd7:    c = first[63:56];
            4'd8:    c = ext[7:0];
            4'd9:    c = ext[15:8];
            4'd10:   c = ext[23:16];
            default: c = 8'h00;
        endcase
        return c;
    endfunction

    // sub plus all name characters, modulo 256, as an adder tree
    function automatic logic [7:0] name_sum(input logic [63:0] first,
                                            input logic [23:0] ext);
        logic [7:0] a;
        logic [7:0] b;
        logic [7:0] c;
        a = (first[7:0] + first[15:8]) + (first[23:16] + first[31:24]);
        b = (first[39:32] + first[47:40]) + (first[55:48] + first[63:56]);
        c = (ext[7:0] + ext[15:8]) + (ext[23:16] + CH_SUB);
        return (a + b) + c;
    endfunction

endpackage

/* rtl/m7fs_outbuf.sv */
// two-entry result buffer feeding the output stream
module m7fs_outbuf (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  m7fs_pkg::t_push     i_push,
    output logic                o_can_load,
    output logic                o_valid,
    input  logic                i_ready,
    output m7fs_pkg::t_result   o_res
);

    logic              r_out_valid, n_out_valid;
    logic              r_pend_valid, n_pend_valid;
    m7fs_pkg::t_result r_out, n_out;
    m7fs_pkg::t_result r_pend, n_pend;
    logic              out_fire;

    assign out_fire   = r_out_valid & i_ready;
    assign o_can_load = !r_pend_valid && (!r_out_valid || out_fire);
    assign o_valid    = r_out_valid;
    assign o_res      = r_out;

    always_comb begin
        n_out_valid  = r_out_valid;
        n_pend_valid = r_pend_valid;
        n_out        = r_out;
        n_pend       = r_pend;
        if (i_push.load) begin
            n_out_valid  = 1'b1;
            n_out        = i_push.r0;
            n_pend_valid = i_push.two;
            n_pend       = i_push.r1;
        end else if (out_fire) begin
            // second result of a pair moves up
            if (r_pend_valid) begin
                n_out        = r_pend;
                n_pend_valid = 1'b0;
            end else begin
                n_out_valid = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_pend_valid <= 1'b0;
        end else begin
            r_out_valid  <= n_out_valid;
            r_pend_valid <= n_pend_valid;
        end
        r_out  <= n_out;
        r_pend <= n_pend;
    end

endmodule

/* rtl/m7fs_core.sv */
// input register, configuration registers and handshake state logic
module m7fs_core (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  logic [1:0]          i_cfg_idx,
    input  logic [63:0]         i_cfg_data,
    input  logic                i_valid,
    output logic                o_ready,
    input  logic [1:0]          i_mode,
    input  logic [7:0]          i_rx_byte,
    input  logic                i_carrier,
    input  logic                i_can_load,
    output m7fs_pkg::t_push     o_push
);

    logic [63:0]          r_name_first;
    logic [23:0]          r_name_ext;
    logic [3:0]           r_retry_limit;

    logic                 r_in_valid, n_in_valid;
    m7fs_pkg::t_mode      r_mode;
    logic [7:0]           r_rx;
    logic                 r_carrier;

    m7fs_pkg::t_phase     r_phase, n_phase;
    logic [3:0]           r_retry, n_retry;
    logic [3:0]           r_char, n_char;
    logic [7:0]           r_sum, n_sum;

    logic                 in_fire;
    logic                 proc;
    logic                 waiting;
    logic                 rx_event;
    logic [3:0]           retry_inc;
    logic                 exhausted;
    m7fs_pkg::t_status    retry_status;
    m7fs_pkg::t_phase     retry_phase;
    m7fs_pkg::t_push      push;

    assign o_ready  = !r_in_valid || i_can_load;
    assign in_fire  = i_valid && o_ready;
    assign proc     = r_in_valid && i_can_load;
    assign o_push   = push;

    assign waiting  = (r_phase == m7fs_pkg::PH_NAK) || (r_phase == m7fs_pkg::PH_ACK) ||
                      (r_phase == m7fs_pkg::PH_CKSM);
    assign rx_event = (r_mode == m7fs_pkg::MODE_RX);

    // retry count saturates, then the limit decides between wait-nak and failure
    assign retry_inc    = (r_retry == m7fs_pkg::RETRY_MAX) ? r_retry : r_retry + 4'd1;
    assign exhausted    = retry_inc >= r_retry_limit;
    assign retry_status = exhausted ? m7fs_pkg::ST_RETRY : m7fs_pkg::ST_BUSY;
    assign retry_phase  = exhausted ? m7fs_pkg::PH_DONE : m7fs_pkg::PH_NAK;

    always_comb begin
        n_in_valid = r_in_valid;
        if (in_fire) begin
            n_in_valid = 1'b1;
        end else if (proc) begin
            n_in_valid = 1'b0;
        end
    end

    always_comb begin
        n_phase = r_phase;
        n_retry = r_retry;
        n_char  = r_char;
        n_sum   = r_sum;

        push.load        = proc;
        push.two         = 1'b0;
        push.r0.has_byte = 1'b0;
        push.r0.tx_byte  = 8'h00;
        push.r0.status   = m7fs_pkg::ST_BUSY;
        push.r0.last     = 1'b1;
        push.r1.has_byte = 1'b0;
        push.r1.tx_byte  = 8'h00;
        push.r1.status   = m7fs_pkg::ST_BUSY;
        push.r1.last     = 1'b1;

        if (r_mode == m7fs_pkg::MODE_START) begin
            n_sum   = m7fs_pkg::name_sum(r_name_first, r_name_ext);
            n_retry = 4'd0;
            n_char  = 4'd0;
            if (r_retry_limit == 4'd0) begin
                n_phase        = m7fs_pkg::PH_DONE;
                push.r0.status = m7fs_pkg::ST_RETRY;
            end else if (!r_carrier) begin
                n_phase        = m7fs_pkg::PH_DONE;
                push.r0.status = m7fs_pkg::ST_CARRIER;
            end else begin
                n_phase = m7fs_pkg::PH_NAK;
            end
        end else if (r_mode == m7fs_pkg::MODE_NONE || !waiting) begin
            push.r0.status = waiting ? m7fs_pkg::ST_BUSY : m7fs_pkg::ST_IDLE;
        end else if (!r_carrier) begin
            n_phase        = m7fs_pkg::PH_DONE;
            push.r0.status = m7fs_pkg::ST_CARRIER;
        end else if (r_phase == m7fs_pkg::PH_NAK) begin
            if (rx_event && r_rx == m7fs_pkg::CH_NAK) begin
                push.two         = 1'b1;
                push.r0.has_byte = 1'b1;
                push.r0.tx_byte  = m7fs_pkg::CH_ACK;
                push.r0.last     = 1'b0;
                push.r1.has_byte = 1'b1;
                push.r1.tx_byte  = m7fs_pkg::name_char(r_name_first, r_name_ext, 4'd0);
                n_char           = 4'd1;
                n_phase          = m7fs_pkg::PH_ACK;
            end else begin
                // no 'u' while still waiting for the first nak
                n_retry        = retry_inc;
                n_phase        = retry_phase;
                push.r0.status = retry_status;
            end
        end else if (r_phase == m7fs_pkg::PH_ACK && rx_event &&
                     r_rx == m7fs_pkg::CH_ACK) begin
            push.r0.has_byte = 1'b1;
            if (r_char >= m7fs_pkg::LAST_INDEX) begin
                n_phase         = m7fs_pkg::PH_CKSM;
                push.r0.tx_byte = m7fs_pkg::CH_SUB;
            end else begin
                push.r0.tx_byte = m7fs_pkg::name_char(r_name_first, r_name_ext, r_char);
                n_char          = r_char + 4'd1;
            end
        end else if (r_phase == m7fs_pkg::PH_CKSM && rx_event && r_rx == r_sum) begin
            n_phase          = m7fs_pkg::PH_DONE;
            push.r0.has_byte = 1'b1;
            push.r0.tx_byte  = m7fs_pkg::CH_ACK;
            push.r0.status   = m7fs_pkg::ST_OK;
        end else begin
            n_retry          = retry_inc;
            n_phase          = retry_phase;
            push.r0.has_byte = 1'b1;
            push.r0.tx_byte  = m7fs_pkg::CH_U;
            push.r0.status   = retry_status;
        end

        if (!proc) begin
            n_phase = r_phase;
            n_retry = r_retry;
            n_char  = r_char;
            n_sum   = r_sum;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_name_first  <= m7fs_pkg::NAME_FIRST_RST;
            r_name_ext    <= m7fs_pkg::NAME_EXT_RST;
            r_retry_limit <= m7fs_pkg::RETRY_LIM_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                m7fs_pkg::CFG_NAME_FIRST: r_name_first  <= i_cfg_data;
                m7fs_pkg::CFG_NAME_EXT:   r_name_ext    <= i_cfg_data[23:0];
                m7fs_pkg::CFG_RETRY_LIM:  r_retry_limit <= i_cfg_data[3:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
            r_phase    <= m7fs_pkg::PH_IDLE;
            r_retry    <= 4'd0;
            r_char     <= 4'd0;
            r_sum      <= 8'h00;
        end else begin
            r_in_valid <= n_in_valid;
            r_phase    <= n_phase;
            r_retry    <= n_retry;
            r_char     <= n_char;
            r_sum      <= n_sum;
        end
        if (in_fire) begin
            r_mode    <= m7fs_pkg::t_mode'(i_mode);
            r_rx      <= i_rx_byte;
            r_carrier <= i_carrier;
        end
    end

endmodule

/* rtl/modem7_filename_sender_top.sv */
// top level of the modem7 filename sender
//
// the sender side of the modem7 batch filename exchange. each request on the
// s_axis channel is a line event: start, received byte or receive timeout,
// with the carrier flag. each event gives one or two result requests on
// m_axis: a byte to transmit (when tuser is set) and the transfer status;
// tlast marks the final result of the event. the 11-character name and the
// retry limit are written through the i_cfg port; the user must do so only
// while no event is pending, the block does not enforce it. an accepted
// event is registered, decoded once the two-entry output buffer can load and
// its results are written to that buffer. events with one result can follow
// every cycle while m_axis does not stall; a nak in wait-nak yields two results
// and holds the next event until its second result has moved up in the buffer.
// a stall on m_axis holds the results in the buffer and backs up into the
// input register, then drops s_axis_tready. synchronous reset empties both
// stages, sets the phase to idle and loads the space-padded default name
// and a retry limit of ten.
module modem7_filename_sender_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [63:0] i_cfg_data,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // rx_byte [7:0], carrier [8], zero [15:9]
    input  logic [1:0]  s_axis_tuser,   // mode [1:0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // tx_byte [7:0], status [10:8], zero [15:11]
    output logic        m_axis_tuser,   // has_byte
    output logic        m_axis_tlast
);

    m7fs_pkg::t_push   push;
    m7fs_pkg::t_result res;
    logic              can_load;

    m7fs_core u_core (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_valid    (s_axis_tvalid),
        .o_ready    (s_axis_tready),
        .i_mode     (s_axis_tuser),
        .i_rx_byte  (s_axis_tdata[7:0]),
        .i_carrier  (s_axis_tdata[8]),
        .i_can_load (can_load),
        .o_push     (push)
    );

    m7fs_outbuf u_outbuf (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (push),
        .o_can_load (can_load),
        .o_valid    (m_axis_tvalid),
        .i_ready    (m_axis_tready),
        .o_res      (res)
    );

    assign m_axis_tdata = {5'b00000, res.status, res.tx_byte};
    assign m_axis_tuser = res.has_byte;
    assign m_axis_tlast = res.last;

endmodule

/* bench/tb_top.sv */
`timescale 1ns / 100ps
// testbench for the modem7 filename sender: line events in, predicted replies checked out
module tb_top;
    import m7fs_pkg::*;

    localparam int CYCLE_LIMIT  = 400000;
    localparam int HOLD_AFTER   = 900;
    localparam int HOLD_CYCLES  = 300;
    localparam int PHASE_EVENTS = 230;
    localparam int TAIL_CYCLES  = 8;

    // predicts the replies of the sender and keeps those not yet seen
    class filename_scoreboard;
        logic [63:0] name_lo;
        logic [23:0] name_hi;
        logic [3:0]  retry_lim;
        t_phase      phase;
        logic [3:0]  retries;
        logic [3:0]  char_idx;
        logic [7:0]  cksum;
        t_result     reply[2];
        t_result     pending_replies[$];
        int          mismatches;

        function new();
            name_lo    = NAME_FIRST_RST;
            name_hi    = NAME_EXT_RST;
            retry_lim  = RETRY_LIM_RST;
            phase      = PH_IDLE;
            retries    = 4'd0;
            char_idx   = 4'd0;
            cksum      = 8'h00;
            mismatches = 0;
        endfunction

        function void write_reg(logic [1:0] idx, logic [63:0] data);
            if (idx == CFG_NAME_FIRST) name_lo = data;
            else if (idx == CFG_NAME_EXT) name_hi = data[23:0];
            else if (idx == CFG_RETRY_LIM) retry_lim = data[3:0];
        endfunction

        function logic [7:0] char_at(logic [3:0] i);
            if (i < 4'd8) return name_lo[8*i +: 8];
            if (i < NAME_LENGTH) return name_hi[8*(i-4'd8) +: 8];
            return 8'h00;
        endfunction

        function logic [7:0] name_checksum();
            logic [7:0] s;
            s = CH_SUB;
            for (int i = 0; i < NAME_LENGTH; i++) s = s + char_at(4'(i));
            return s;
        endfunction

        function t_result make_reply(logic has, logic [7:0] b, t_status st, logic fin);
            t_result r;
            r.has_byte = has;
            r.tx_byte  = has ? b : 8'h00;
            r.status   = st;
            r.last     = fin;
            return r;
        endfunction

        function t_status enter_wait_nak();
            if (retries >= retry_lim) begin
                phase = PH_DONE;
                return ST_RETRY;
            end
            phase = PH_NAK;
            return ST_BUSY;
        endfunction

        function void count_retry();
            if (retries != RETRY_MAX) retries = retries + 4'd1;
        endfunction

        // advances the state by one line event, replies land in reply[]
        function int step_sender(t_mode mode, logic [7:0] rx, logic car);
            logic    waiting;
            t_status st;
            waiting = (phase == PH_NAK) || (phase == PH_ACK) || (phase == PH_CKSM);
            if (mode == MODE_START) begin
                cksum    = name_checksum();
                retries  = 4'd0;
                char_idx = 4'd0;
                st = enter_wait_nak();
                if (st == ST_BUSY && !car) begin
                    phase = PH_DONE;
                    st = ST_CARRIER;
                end
                reply[0] = make_reply(1'b0, 8'h00, st, 1'b1);
                return 1;
            end
            if (mode == MODE_NONE || !waiting) begin
                reply[0] = make_reply(1'b0, 8'h00, waiting ? ST_BUSY : ST_IDLE, 1'b1);
                return 1;
            end
            // carrier is checked before the event itself
            if (!car) begin
                phase = PH_DONE;
                reply[0] = make_reply(1'b0, 8'h00, ST_CARRIER, 1'b1);
                return 1;
            end
            if (phase == PH_NAK) begin
                if (mode == MODE_RX && rx == CH_NAK) begin
                    reply[0] = make_reply(1'b1, CH_ACK, ST_BUSY, 1'b0);
                    reply[1] = make_reply(1'b1, char_at(4'd0), ST_BUSY, 1'b1);
                    char_idx = 4'd1;
                    phase = PH_ACK;
                    return 2;
                end
                count_retry();
                st = enter_wait_nak();
                reply[0] = make_reply(1'b0, 8'h00, st, 1'b1);
                return 1;
            end
            if (phase == PH_ACK) begin
                if (mode == MODE_RX && rx == CH_ACK) begin
                    if (char_idx >= NAME_LENGTH) begin
                        phase = PH_CKSM;
                        reply[0] = make_reply(1'b1, CH_SUB, ST_BUSY, 1'b1);
                    end else begin
                        reply[0] = make_reply(1'b1, char_at(char_idx), ST_BUSY, 1'b1);
                        char_idx = char_idx + 4'd1;
                    end
                    return 1;
                end
            end else if (mode == MODE_RX && rx == cksum) begin
                phase = PH_DONE;
                reply[0] = make_reply(1'b1, CH_ACK, ST_OK, 1'b1);
                return 1;
            end
            // wrong byte or timeout after the name started: 'u' and back to wait-nak, or done once retries run out
            count_retry();
            st = enter_wait_nak();
            reply[0] = make_reply(1'b1, CH_U, st, 1'b1);
            return 1;
        endfunction

        function void note_event(t_mode mode, logic [7:0] rx, logic car);
            int n;
            n = step_sender(mode, rx, car);
            for (int i = 0; i < n; i++) pending_replies.push_back(reply[i]);
        endfunction

        function void check_reply(t_result got);
            t_result want;
            if (pending_replies.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected reply: has_byte %0b tx_byte %h status %0d last %0b",
                             got.has_byte, got.tx_byte, got.status, got.last);
                return;
            end
            want = pending_replies.pop_front();
            if (got.has_byte !== want.has_byte || got.tx_byte !== want.tx_byte ||
                got.status !== want.status || got.last !== want.last) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("reply mismatch: exp %0b/%h/%0d/%0b got %0b/%h/%0d/%0b",
                             want.has_byte, want.tx_byte, want.status, want.last,
                             got.has_byte, got.tx_byte, got.status, got.last);
            end
        endfunction
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic [1:0]  i_cfg_idx = CFG_NAME_FIRST;
    logic [63:0] i_cfg_data = 64'd0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [15:0] s_axis_tdata = 16'd0;
    logic [1:0]  s_axis_tuser = MODE_NONE;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [15:0] m_axis_tdata;
    logic        m_axis_tuser;
    logic        m_axis_tlast;

    int   cycle_count = 0;
    int   accepted_events = 0;
    logic hold_off = 1'b0;
    logic quiet;

    filename_scoreboard sb = new();
    // tracks the sender at the time events are generated, to steer the stimulus
    filename_scoreboard shadow = new();

    modem7_filename_sender_top u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    always @(posedge i_clk) cycle_count <= cycle_count + 1;

    // stretch with no idling on either side
    assign quiet = (cycle_count >= 2000) && (cycle_count < 3500);

    always @(posedge i_clk)
        m_axis_tready <= !hold_off && (quiet || $urandom_range(99) >= 14);

    // long receiver stall while the sender keeps offering
    initial begin
        wait (accepted_events >= HOLD_AFTER);
        @(posedge i_clk);
        hold_off <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge i_clk);
        hold_off <= 1'b0;
    end

    always @(posedge i_clk) begin
        if (i_rst_n && s_axis_tvalid && s_axis_tready) begin
            sb.note_event(t_mode'(s_axis_tuser), s_axis_tdata[7:0], s_axis_tdata[8]);
            accepted_events <= accepted_events + 1;
        end
    end

    always @(posedge i_clk) begin
        t_result got;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got.has_byte = m_axis_tuser;
            got.tx_byte  = m_axis_tdata[7:0];
            got.status   = t_status'(m_axis_tdata[10:8]);
            got.last     = m_axis_tlast;
            sb.check_reply(got);
        end
    end

    initial begin
        while (cycle_count < CYCLE_LIMIT) @(posedge i_clk);
        $display("tb_top failed");
        $finish;
    end

    task automatic send_event(t_mode mode, logic [7:0] rx, logic car);
        while (!quiet && $urandom_range(99) < 14) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {7'd0, car, rx};
        s_axis_tuser  <= mode;
        void'(shadow.step_sender(mode, rx, car));
        do @(posedge i_clk); while (!s_axis_tready);
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        // let the last accepted request reach the scoreboard first
        @(posedge i_clk);
        while (sb.pending_replies.size() != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_config(logic [63:0] lo, logic [23:0] hi, logic [3:0] lim);
        sb.write_reg(CFG_NAME_FIRST, lo);
        sb.write_reg(CFG_NAME_EXT, {40'd0, hi});
        sb.write_reg(CFG_RETRY_LIM, {60'd0, lim});
        shadow.write_reg(CFG_NAME_FIRST, lo);
        shadow.write_reg(CFG_NAME_EXT, {40'd0, hi});
        shadow.write_reg(CFG_RETRY_LIM, {60'd0, lim});
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= CFG_NAME_FIRST;
        i_cfg_data <= lo;
        @(posedge i_clk);
        i_cfg_idx  <= CFG_NAME_EXT;
        i_cfg_data <= {40'd0, hi};
        @(posedge i_clk);
        i_cfg_idx  <= CFG_RETRY_LIM;
        i_cfg_data <= {60'd0, lim};
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    // mostly a clean transfer for the current phase, sometimes noise
    task automatic next_event(int noise);
        int    r;
        t_mode mode;
        logic [7:0] rx;
        logic  car;
        if ($urandom_range(99) < noise) begin
            r = $urandom_range(99);
            mode = (r < 40) ? MODE_RX : (r < 70) ? MODE_TIMEOUT :
                   (r < 85) ? MODE_START : MODE_NONE;
            rx  = 8'($urandom);
            car = ($urandom_range(99) < 80);
        end else begin
            car = 1'b1;
            case (shadow.phase)
                PH_NAK:  begin mode = MODE_RX; rx = CH_NAK; end
                PH_ACK:  begin mode = MODE_RX; rx = CH_ACK; end
                PH_CKSM: begin mode = MODE_RX; rx = shadow.cksum; end
                default: begin mode = MODE_START; rx = 8'($urandom); end
            endcase
        end
        send_event(mode, rx, car);
    endtask

    initial begin
        logic [63:0] lo;
        logic [23:0] hi;
        logic [3:0]  lim;
        int          noise;

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: reset name and limit
        send_event(MODE_RX, CH_NAK, 1'b1);       // byte while idle
        send_event(MODE_START, 8'h00, 1'b0);     // start without carrier
        send_event(MODE_TIMEOUT, 8'h00, 1'b1);   // timeout while done
        send_event(MODE_START, 8'hFF, 1'b1);
        send_event(MODE_NONE, 8'h55, 1'b1);      // unused mode while waiting
        send_event(MODE_RX, 8'hFF, 1'b1);        // wrong byte in wait-nak
        send_event(MODE_RX, CH_NAK, 1'b1);
        send_event(MODE_RX, 8'h00, 1'b1);        // wrong byte mid-name
        send_event(MODE_RX, CH_NAK, 1'b1);
        repeat (NAME_LENGTH) send_event(MODE_RX, CH_ACK, 1'b1);
        send_event(MODE_RX, shadow.cksum, 1'b1);
        drain();

        // limit zero: exhausted right at start
        set_config(64'd0, 24'd0, 4'd0);
        send_event(MODE_START, 8'h00, 1'b1);
        drain();

        // limit one: 'u' that also exhausts, then carrier lost while waiting
        set_config({64{1'b1}}, {24{1'b1}}, 4'd1);
        send_event(MODE_START, 8'h00, 1'b1);
        send_event(MODE_RX, CH_NAK, 1'b1);
        send_event(MODE_TIMEOUT, 8'h00, 1'b1);
        send_event(MODE_START, 8'h00, 1'b1);
        send_event(MODE_RX, CH_NAK, 1'b0);

        for (int p = 0; p < 8; p++) begin
            drain();
            lo    = {$urandom, $urandom};
            hi    = 24'($urandom);
            lim   = 4'($urandom_range(15, 1));
            noise = $urandom_range(15, 4);
            case (p)
                0: begin lo = 64'd0; hi = 24'd0; lim = 4'd15; noise = 8; end
                1: begin lo = {64{1'b1}}; hi = {24{1'b1}}; lim = 4'd1; noise = 25; end
                4: begin lim = 4'd15; noise = 40; end
                5: begin lim = 4'd2; noise = 30; end
                default: ;
            endcase
            set_config(lo, hi, lim);
            repeat (PHASE_EVENTS) next_event(noise);
        end
        drain();

        if (sb.mismatches == 0 && sb.pending_replies.size() == 0)
            $display("tb_top passed");
        else
            $display("tb_top failed");
        $finish;
    end

endmodule

/* sim.f */
rtl/m7fs_pkg.sv
rtl/m7fs_outbuf.sv
rtl/m7fs_core.sv
rtl/modem7_filename_sender_top.sv
bench/tb_top.sv
